FILE: src/ert_pkg.sv
// package for the exact-match route table: sizes, command and status codes,
// request, response and table entry types
// no dependencies
package ert_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int EC_W = 6;

   localparam logic [1:0] CMD_CREATE = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_UPDATE = 2'd2;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_NOMATCH = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] dest_addr;
      logic [5:0]  prefix_len;
      logic [31:0] gateway_addr;
      logic [7:0]  out_iface;
   } req_type;

   typedef struct packed {
      logic [1:0]      status;
      logic [EC_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] dest_addr;
      logic [5:0]  prefix_len;
      logic [31:0] gateway_addr;
      logic [7:0]  out_iface;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

FILE: src/exact_match_route_table.sv
// exact-match route table: sequencer over one entry ram, newest entry at the top address
// create: response in the next cycle; delete/update: search walks one entry a
// cycle from the newest, delete then shifts one entry a cycle
// through the ram write port; one request at a time, busy while working
// synchronous active-high reset empties the table; the receiver cannot stall responses
// depends on ert_pkg and ert_ram
module exact_match_route_table
   import ert_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;

   logic [1:0]        state_ff, state_in;
   req_type           req_ff, req_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] cmp_addr_ff, cmp_addr_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [ADDR_W-1:0] ram_raddr;
   entry_type         ram_wdata;
   entry_type         ram_rdata;
   logic [ENTRY_W-1:0] ram_rdata_raw;

   logic [CNT_W-1:0]  count_m1;
   logic [CNT_W-1:0]  cmp_ext;
   logic              hit;

   function automatic logic [EC_W-1:0] to_ec(input logic [CNT_W-1:0] c);
      logic [CNT_W+EC_W-1:0] e;
      e = {{EC_W{1'b0}}, c};
      return e[EC_W-1:0];
   endfunction

   ert_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata_raw)
   );

   assign ram_rdata = ram_rdata_raw;
   assign count_m1 = count_ff - CNT_W'(1);
   assign cmp_ext = CNT_W'(cmp_addr_ff);
   assign hit = (ram_rdata.dest_addr == req_ff.dest_addr) &&
                (ram_rdata.prefix_len == req_ff.prefix_len) &&
                (ram_rdata.gateway_addr == req_ff.gateway_addr);

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      count_in = count_ff;
      cmp_addr_in = cmp_addr_ff;
      rd_addr_in = rd_addr_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      ram_we = 1'b0;
      ram_waddr = cmp_addr_ff;
      ram_wdata = ram_rdata;
      ram_raddr = rd_addr_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               case (req_data.cmd)
                  CMD_CREATE: begin
                     if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.status = ST_FULL;
                        rsp_in.entry_count = to_ec(count_ff);
                     end else begin
                        ram_we = 1'b1;
                        ram_waddr = count_ff[ADDR_W-1:0];
                        ram_wdata.dest_addr = req_data.dest_addr;
                        ram_wdata.prefix_len = req_data.prefix_len;
                        ram_wdata.gateway_addr = req_data.gateway_addr;
                        ram_wdata.out_iface = req_data.out_iface;
                        count_in = count_ff + CNT_W'(1);
                        rsp_valid_in = 1'b1;
                        rsp_in.status = ST_DONE;
                        rsp_in.entry_count = to_ec(count_ff + CNT_W'(1));
                     end
                  end
                  CMD_DELETE, CMD_UPDATE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.status = ST_NOMATCH;
                        rsp_in.entry_count = to_ec(count_ff);
                     end else begin
                        ram_raddr = count_m1[ADDR_W-1:0];
                        cmp_addr_in = count_m1[ADDR_W-1:0];
                        rd_addr_in = count_m1[ADDR_W-1:0] - ADDR_W'(1);
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.status = ST_NOMATCH;
                     rsp_in.entry_count = to_ec(count_ff);
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (hit) begin
               if (req_ff.cmd == CMD_UPDATE) begin
                  ram_we = 1'b1;
                  ram_wdata.out_iface = req_ff.out_iface;
                  rsp_valid_in = 1'b1;
                  rsp_in.status = ST_DONE;
                  rsp_in.entry_count = to_ec(count_ff);
                  state_in = S_IDLE;
               end else if (cmp_ext == count_m1) begin
                  count_in = count_m1;
                  rsp_valid_in = 1'b1;
                  rsp_in.status = ST_DONE;
                  rsp_in.entry_count = to_ec(count_m1);
                  state_in = S_IDLE;
               end else begin
                  ram_raddr = cmp_addr_ff + ADDR_W'(1);
                  state_in = S_SHIFT;
               end
            end else if (cmp_addr_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = ST_NOMATCH;
               rsp_in.entry_count = to_ec(count_ff);
               state_in = S_IDLE;
            end else begin
               ram_raddr = rd_addr_ff;
               cmp_addr_in = rd_addr_ff;
               rd_addr_in = rd_addr_ff - ADDR_W'(1);
            end
         end
         S_SHIFT: begin
            // move the entry above down into the gap
            ram_we = 1'b1;
            if (cmp_ext + CNT_W'(1) == count_m1) begin
               count_in = count_m1;
               rsp_valid_in = 1'b1;
               rsp_in.status = ST_DONE;
               rsp_in.entry_count = to_ec(count_m1);
               state_in = S_IDLE;
            end else begin
               ram_raddr = cmp_addr_ff + ADDR_W'(2);
               cmp_addr_in = cmp_addr_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      cmp_addr_ff <= cmp_addr_in;
      rd_addr_ff <= rd_addr_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

FILE: src/ert_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module ert_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: verif/tb.sv
// testbench for exact_match_route_table: random and directed create, delete and update
// requests, checked against a shadow route table kept in the testbench
// depends on ert_pkg and the route table rtl
module tb;
   import ert_pkg::*;

   localparam int CLOCK_HALF = 4;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1750;
   localparam int PHASE_LEN = 125;
   localparam int POOL_SIZE = 8;
   localparam int DRAIN_CYCLES = 120;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int REPORT_MAX = 10;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   req_type   request_q[$];
   rsp_type   outcome_q[$];
   entry_type route_shadow[TABLE_DEPTH];
   int        route_count = 0;
   entry_type key_pool[POOL_SIZE];
   int        items_total = 0;
   int        items_accepted = 0;
   int        gap_left = 0;
   bit        burst_mode = 1'b0;
   int        fail_count = 0;
   int        cycle_count = 0;

   exact_match_route_table u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #CLOCK_HALF clock = ~clock;

   function automatic bit key_hit(entry_type e, req_type r);
      return e.dest_addr == r.dest_addr && e.prefix_len == r.prefix_len &&
             e.gateway_addr == r.gateway_addr;
   endfunction

   task automatic apply_route_op(input req_type r);
      rsp_type outcome;
      int      hit;
      int      i;
      outcome.status = ST_NOMATCH;
      hit = -1;
      if (r.cmd == CMD_DELETE || r.cmd == CMD_UPDATE) begin
         for (i = 0; i < route_count; i++) begin
            if (hit < 0 && key_hit(route_shadow[i], r)) begin
               hit = i;
            end
         end
      end
      case (r.cmd)
         CMD_CREATE: begin
            if (route_count >= TABLE_DEPTH) begin
               outcome.status = ST_FULL;
            end else begin
               for (i = route_count; i > 0; i--) begin
                  route_shadow[i] = route_shadow[i-1];
               end
               route_shadow[0].dest_addr = r.dest_addr;
               route_shadow[0].prefix_len = r.prefix_len;
               route_shadow[0].gateway_addr = r.gateway_addr;
               route_shadow[0].out_iface = r.out_iface;
               route_count++;
               outcome.status = ST_DONE;
            end
         end
         CMD_DELETE: begin
            if (hit >= 0) begin
               for (i = hit; i + 1 < route_count; i++) begin
                  route_shadow[i] = route_shadow[i+1];
               end
               route_count--;
               outcome.status = ST_DONE;
            end
         end
         CMD_UPDATE: begin
            if (hit >= 0) begin
               route_shadow[hit].out_iface = r.out_iface;
               outcome.status = ST_DONE;
            end
         end
         default: begin
         end
      endcase
      outcome.entry_count = EC_W'(route_count);
      outcome_q.push_back(outcome);
   endtask

   function automatic req_type make_req(logic [1:0] cmd, logic [31:0] dst, logic [5:0] plen,
                                        logic [31:0] gw, logic [7:0] oif);
      req_type r;
      r.cmd = cmd;
      r.dest_addr = dst;
      r.prefix_len = plen;
      r.gateway_addr = gw;
      r.out_iface = oif;
      return r;
   endfunction

   function automatic logic [5:0] random_prefix();
      if ($urandom_range(0, 9) == 0) begin
         return 6'($urandom_range(33, 63));
      end
      return 6'($urandom_range(0, 32));
   endfunction

   // fill phases lean on create, drain phases on delete; keys mostly come from a small pool
   function automatic req_type random_route_op(bit fill_phase);
      req_type   r;
      entry_type k;
      int        pick;
      pick = $urandom_range(0, 99);
      if (fill_phase) begin
         r.cmd = (pick < 65) ? CMD_CREATE : (pick < 80) ? CMD_DELETE :
                 (pick < 97) ? CMD_UPDATE : CMD_UNUSED;
      end else begin
         r.cmd = (pick < 20) ? CMD_CREATE : (pick < 75) ? CMD_DELETE :
                 (pick < 97) ? CMD_UPDATE : CMD_UNUSED;
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         if (pick < 8) begin
            case ($urandom_range(0, 2))
               0: k.dest_addr[$urandom_range(0, 31)] ^= 1'b1;
               1: k.prefix_len[$urandom_range(0, 5)] ^= 1'b1;
               default: k.gateway_addr[$urandom_range(0, 31)] ^= 1'b1;
            endcase
         end
      end else begin
         k.dest_addr = $urandom;
         k.prefix_len = random_prefix();
         k.gateway_addr = $urandom;
      end
      r.dest_addr = k.dest_addr;
      r.prefix_len = k.prefix_len;
      r.gateway_addr = k.gateway_addr;
      r.out_iface = 8'($urandom);
      return r;
   endfunction

   function automatic int request_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (burst_mode || roll < 50) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else begin
         if (start && !busy) begin
            apply_route_op(req_data);
            items_accepted++;
         end
         if ($urandom_range(0, 63) == 0) begin
            burst_mode <= ~burst_mode;
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               start <= 1'b0;
            end else if (request_q.size() > 0) begin
               req_data <= request_q.pop_front();
               start <= 1'b1;
               gap_left <= request_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (outcome_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
               $display("unexpected response: status %0d count %0d",
                        rsp_data.status, rsp_data.entry_count);
            end
         end else begin
            want = outcome_q.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.entry_count !== want.entry_count) begin
               fail_count++;
               if (fail_count <= REPORT_MAX) begin
                  $display("mismatch: status exp %0d got %0d, count exp %0d got %0d",
                           want.status, rsp_data.status,
                           want.entry_count, rsp_data.entry_count);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int n;
      // directed: empty table, extremes, duplicates, near misses, unused code
      request_q.push_back(make_req(CMD_DELETE, 32'h0a000001, 6'd24, 32'h0a0000fe, 8'h01));
      request_q.push_back(make_req(CMD_UPDATE, 32'h0a000001, 6'd24, 32'h0a0000fe, 8'h02));
      request_q.push_back(make_req(CMD_CREATE, 32'h0, 6'd0, 32'h0, 8'h00));
      request_q.push_back(make_req(CMD_CREATE, '1, 6'd63, '1, 8'hff));
      request_q.push_back(make_req(CMD_CREATE, '1, 6'd63, '1, 8'h5a));
      request_q.push_back(make_req(CMD_UPDATE, '1, 6'd63, '1, 8'h11));
      request_q.push_back(make_req(CMD_UNUSED, '1, 6'd63, '1, 8'h22));
      request_q.push_back(make_req(CMD_UNUSED, 32'h0, 6'd0, 32'h0, 8'h00));
      request_q.push_back(make_req(CMD_DELETE, '1, 6'd32, '1, 8'h00));
      request_q.push_back(make_req(CMD_UPDATE, 32'hfffffffe, 6'd63, '1, 8'h33));
      request_q.push_back(make_req(CMD_DELETE, '1, 6'd63, 32'h7fffffff, 8'h00));
      request_q.push_back(make_req(CMD_DELETE, '1, 6'd63, '1, 8'h00));
      request_q.push_back(make_req(CMD_DELETE, '1, 6'd63, '1, 8'h00));
      request_q.push_back(make_req(CMD_DELETE, '1, 6'd63, '1, 8'h00));
      request_q.push_back(make_req(CMD_CREATE, 32'hc0a80001, 6'd32, 32'hc0a800fe, 8'h03));
      request_q.push_back(make_req(CMD_UPDATE, 32'hc0a80001, 6'd32, 32'hc0a800fe, 8'h80));
      request_q.push_back(make_req(CMD_DELETE, 32'h0, 6'd0, 32'h0, 8'hff));
      request_q.push_back(make_req(CMD_DELETE, 32'hc0a80001, 6'd32, 32'hc0a800fe, 8'h00));
      request_q.push_back(make_req(CMD_DELETE, 32'hc0a80001, 6'd32, 32'hc0a800fe, 8'h00));

      key_pool[0] = '{dest_addr: 32'h0, prefix_len: 6'd0, gateway_addr: '1, out_iface: 8'h0};
      key_pool[1] = '{dest_addr: '1, prefix_len: 6'd32, gateway_addr: 32'h0, out_iface: 8'h0};
      key_pool[2] = '{dest_addr: $urandom, prefix_len: 6'd63, gateway_addr: $urandom,
                      out_iface: 8'h0};
      for (n = 3; n < POOL_SIZE; n++) begin
         key_pool[n].dest_addr = $urandom;
         key_pool[n].prefix_len = 6'($urandom_range(0, 32));
         key_pool[n].gateway_addr = $urandom;
         key_pool[n].out_iface = 8'h0;
      end
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         request_q.push_back(random_route_op(((n / PHASE_LEN) % 2) == 0));
      end
      items_total = request_q.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted != items_total) @(posedge clock);
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/ert_pkg.sv
src/ert_ram.sv
src/exact_match_route_table.sv
verif/tb.sv
